FILE: sv/assert_macros.svh
// Assertion macros shared by the tube saturation stage RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define TSS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tss assertion failed");

// Next-cycle implication, disabled in reset.
`define TSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tss assertion failed");

`endif

FILE: sv/tss_pkg.sv
// Types, constants, tanh table and rounding helpers for the tube saturation stage.
`default_nettype none

package tss_pkg;

   localparam int WORK_FRAC  = 24;
   localparam int TANH_DEPTH = 256;
   localparam int ROM_BITS   = 25;
   localparam int ONE_SHIFT  = 30;

   // step of the exp table in Q2.30: 2*span/depth
   localparam logic [63:0] TANH_STEP = (64'd16 << ONE_SHIFT) / TANH_DEPTH;

   localparam logic [2:0] CFG_DRIVE = 3'd0;
   localparam logic [2:0] CFG_BIAS  = 3'd1;
   localparam logic [2:0] CFG_SAG   = 3'd2;
   localparam logic [2:0] CFG_MIX   = 3'd3;
   localparam logic [2:0] CFG_COEF  = 3'd4;

   localparam logic [15:0] RST_DRIVE = 16'd6554;
   localparam logic [15:0] RST_BIAS  = 16'd3277;
   localparam logic [15:0] RST_SAG   = 16'd6554;
   localparam logic [15:0] RST_MIX   = 16'd26214;
   localparam logic [15:0] RST_COEF  = 16'd65490;

   localparam logic [15:0] UNITY_Q15 = 16'd32768;
   localparam logic [15:0] BYPASS_LIM = 16'd32;
   localparam logic [31:0] K_BIAS    = 32'd26214;  // 0.4 in Q0.16
   localparam logic [31:0] K_SAG     = 32'd9830;   // 0.15 in Q0.16
   localparam logic [31:0] K_NEG     = 32'd55706;  // 0.85 in Q0.16

   typedef logic [ROM_BITS-1:0] tanh_rom_type [0:TANH_DEPTH];

   typedef struct packed {
      logic        busy;
      logic [24:0] value;
   } mk_status_type;

   // restoring divide, elaboration only
   function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] q;
      rem = '0;
      q   = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem  = rem - {1'b0, den};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // tanh(x) over [0,8] from exp(-2x) series, Q.24
   function automatic tanh_rom_type build_tanh();
      tanh_rom_type rom;
      logic [63:0] one;
      logic [63:0] sum;
      logic [63:0] term;
      logic [63:0] p;
      logic [63:0] t;
      one  = 64'd1 << ONE_SHIFT;
      sum  = one;
      term = one;
      p    = one;
      for (int n = 1; n < 48; n++) begin
         term = udiv((term * TANH_STEP) >> ONE_SHIFT, 64'(n));
         if (n % 2 == 1) sum = sum - term;
         else            sum = sum + term;
      end
      for (int k = 0; k <= TANH_DEPTH; k++) begin
         t      = udiv((one - p) << ONE_SHIFT, one + p);
         rom[k] = ROM_BITS'((t + 64'd32) >> 6);
         p      = (p * sum + (one >> 1)) >> ONE_SHIFT;
      end
      return rom;
   endfunction

   localparam tanh_rom_type TANH_ROM = build_tanh();

   // right shift, rounding half away from zero
   function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int sh);
      logic [63:0] m;
      logic [63:0] half;
      if (sh == 0) return v;
      half = 64'd1 << (sh - 1);
      m    = v[63] ? 64'(-v) : 64'(v);
      m    = (m + half) >> sh;
      return v[63] ? -signed'(m) : signed'(m);
   endfunction

   function automatic logic [15:0] cap(input logic [15:0] v);
      return (v > UNITY_Q15) ? UNITY_Q15 : v;
   endfunction

endpackage

`default_nettype wire

FILE: sv/tube_saturation_stage_top.sv
// Top level of the tube saturation stage: sequencer, registers and stream ports.
`default_nettype none

// Asymmetric tanh waveshaper with envelope-driven bias. Each request carries one
// signed Q1.(SAMPLE_BITS-1) sample; each produces exactly one response sample.
// One request is worked at a time: a sequencer steps it through a single shared
// 32x32 multiplier, one state per step. A negative shaper argument takes two
// extra states for the 0.85 scale; a bypassed sample (drive and mix both at or
// below 0.001) goes from acceptance straight to the done state, where every
// result waits for the response side. The next request can be taken in the cycle
// after the response register is loaded. After reset, and after each write of
// drive_amount, the makeup gain is recomputed by a bit-serial root and divider,
// during which req_tready stays low; csr writes are always taken. The response
// register frees the input side while a result waits to be taken.
module tube_saturation_stage_top #(
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   // [SAMPLE_BITS-1:0] sample_in, zero padding above
   input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]  req_tdata,
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [SAMPLE_BITS-1:0] sample_out, zero padding above
   output      logic [((SAMPLE_BITS+7)/8)*8-1:0]  rsp_tdata,
   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire logic [2:0]                        csr_index,
   input  wire logic [15:0]                       csr_data
);

`include "assert_macros.svh"

   localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int FB      = SAMPLE_BITS - 1;
   localparam int WF      = tss_pkg::WORK_FRAC;
   localparam int WSH_L   = (FB <= WF) ? WF - FB : 0;
   localparam int WSH_R   = (FB > WF) ? FB - WF : 0;
   localparam int RSH_L   = (FB >= WF) ? FB - WF : 0;
   localparam int RSH_R   = (FB < WF) ? WF - FB : 0;
   localparam logic signed [63:0] SMAX = (64'sd1 <<< FB) - 64'sd1;
   localparam logic signed [63:0] SMIN = -SMAX - 64'sd1;

   // sequencer codes
   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_X    = 5'd1;
   localparam logic [4:0] ST_ENVC = 5'd2;
   localparam logic [4:0] ST_ENVA = 5'd3;
   localparam logic [4:0] ST_ENVN = 5'd4;
   localparam logic [4:0] ST_GK   = 5'd5;
   localparam logic [4:0] ST_T1   = 5'd6;
   localparam logic [4:0] ST_T2   = 5'd7;
   localparam logic [4:0] ST_U    = 5'd8;
   localparam logic [4:0] ST_A    = 5'd9;
   localparam logic [4:0] ST_IDX  = 5'd10;
   localparam logic [4:0] ST_TANH = 5'd11;
   localparam logic [4:0] ST_NEGM = 5'd12;
   localparam logic [4:0] ST_NEG  = 5'd13;
   localparam logic [4:0] ST_WETM = 5'd14;
   localparam logic [4:0] ST_WET  = 5'd15;
   localparam logic [4:0] ST_MIX1 = 5'd16;
   localparam logic [4:0] ST_MIX2 = 5'd17;
   localparam logic [4:0] ST_MIX3 = 5'd18;
   localparam logic [4:0] ST_RES  = 5'd19;
   localparam logic [4:0] ST_DONE = 5'd20;

   // configuration registers
   logic [15:0] drive_ff, drive_in, bias_ff, bias_in, sag_ff, sag_in;
   logic [15:0] mix_cfg_ff, mix_cfg_in, coef_ff, coef_in;
   logic        dirty_ff, dirty_in;

   // working registers
   logic [4:0]             state_ff, state_in;
   logic [SAMPLE_BITS-1:0] res_ff, res_in, rsp_data_ff, rsp_data_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]     w_ff, w_in, x_ff, x_in, gk_ff, gk_in, t1_ff, t1_in;
   logic signed [31:0]     t2_ff, t2_in, u_ff, u_in, t_ff, t_in, wet_ff, wet_in;
   logic signed [31:0]     mixed_ff, mixed_in;
   logic signed [63:0]     acc_ff, acc_in;
   logic [23:0]            env_ff, env_in;
   logic [31:0]            a_ff, a_in;
   logic                   neg_ff, neg_in, sat_ff, sat_in;
   logic [tss_pkg::ROM_BITS-1:0] lo_ff, lo_in;

   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] prod_ff;

   logic                   mk_start;
   tss_pkg::mk_status_type mk_status;

   logic [15:0]        d_cap, g_cap, m_cap;
   logic               bypass;
   logic signed [63:0] s64, ax64, nu64, r64;
   logic [63:0]        env_sum, tfrac;
   logic [12:0]        idx;
   logic [tss_pkg::ROM_BITS-1:0] lo_rd, hi_rd;
   logic               req_take, rsp_free;

   assign d_cap  = tss_pkg::cap(drive_ff);
   assign g_cap  = tss_pkg::cap(sag_ff);
   assign m_cap  = tss_pkg::cap(mix_cfg_ff);
   assign bypass = (d_cap <= tss_pkg::BYPASS_LIM) && (m_cap <= tss_pkg::BYPASS_LIM);

   assign req_tready = (state_ff == ST_IDLE) && !dirty_ff && !mk_status.busy;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign mk_start   = (state_ff == ST_IDLE) && dirty_ff && !mk_status.busy;

   assign s64   = 64'(signed'(req_tdata[SAMPLE_BITS-1:0]));
   assign ax64  = tss_pkg::rnd(64'(x_ff), 5);
   assign idx   = a_ff[31:19];
   assign lo_rd = tss_pkg::TANH_ROM[{1'b0, idx[7:0]}];
   assign hi_rd = tss_pkg::TANH_ROM[9'({1'b0, idx[7:0]}) + 9'd1];

   always_comb begin
      drive_in   = drive_ff;
      bias_in    = bias_ff;
      sag_in     = sag_ff;
      mix_cfg_in = mix_cfg_ff;
      coef_in    = coef_ff;
      dirty_in   = dirty_ff;
      if (mk_start) dirty_in = 1'b0;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            tss_pkg::CFG_DRIVE: begin
               drive_in = csr_data;
               dirty_in = 1'b1;
            end
            tss_pkg::CFG_BIAS:  bias_in    = csr_data;
            tss_pkg::CFG_SAG:   sag_in     = csr_data;
            tss_pkg::CFG_MIX:   mix_cfg_in = csr_data;
            tss_pkg::CFG_COEF:  coef_in    = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      w_in         = w_ff;
      x_in         = x_ff;
      gk_in        = gk_ff;
      t1_in        = t1_ff;
      t2_in        = t2_ff;
      u_in         = u_ff;
      t_in         = t_ff;
      wet_in       = wet_ff;
      mixed_in     = mixed_ff;
      acc_in       = acc_ff;
      env_in       = env_ff;
      a_in         = a_ff;
      neg_in       = neg_ff;
      sat_in       = sat_ff;
      lo_in        = lo_ff;
      mul_a        = '0;
      mul_b        = '0;
      nu64         = '0;
      env_sum      = '0;
      tfrac        = '0;
      r64          = '0;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               w_in   = 32'(tss_pkg::rnd(s64 <<< WSH_L, WSH_R));
               res_in = req_tdata[SAMPLE_BITS-1:0];
               state_in = bypass ? ST_DONE : ST_X;
            end
         end
         ST_X: begin
            // drive gain 1+24*drive in Q.15
            mul_a    = w_ff;
            mul_b    = signed'(32'(d_cap) * 32'd24 + 32'd32768);
            state_in = ST_ENVC;
         end
         ST_ENVC: begin
            x_in     = 32'(tss_pkg::rnd(prod_ff, 15));
            mul_a    = signed'(32'(env_ff));
            mul_b    = signed'(32'(coef_ff));
            state_in = ST_ENVA;
         end
         ST_ENVA: begin
            acc_in   = prod_ff;
            mul_a    = ax64[63] ? 32'(-ax64) : 32'(ax64);
            mul_b    = signed'(32'd65536 - 32'(coef_ff));
            state_in = ST_ENVN;
         end
         ST_ENVN: begin
            env_sum  = 64'(prod_ff) + 64'(acc_ff) + 64'd32768;
            env_in   = env_sum[39:16];
            mul_a    = signed'(32'(g_cap));
            mul_b    = signed'(tss_pkg::K_SAG);
            state_in = ST_GK;
         end
         ST_GK: begin
            gk_in    = prod_ff[31:0];
            mul_a    = 32'(signed'(bias_ff));
            mul_b    = signed'(tss_pkg::K_BIAS);
            state_in = ST_T1;
         end
         ST_T1: begin
            // bias*512*0.4 then >>16 equals a rounded >>7
            t1_in    = 32'(tss_pkg::rnd(prod_ff, 7));
            mul_a    = signed'(32'(env_ff));
            mul_b    = gk_ff;
            state_in = ST_T2;
         end
         ST_T2: begin
            t2_in    = 32'(tss_pkg::rnd(prod_ff, 26));
            state_in = ST_U;
         end
         ST_U: begin
            u_in     = x_ff + t1_ff - t2_ff;
            state_in = ST_A;
         end
         ST_A: begin
            // negative side: tanh(1.25*|u|)
            neg_in = u_ff[31];
            nu64   = -64'(u_ff);
            if (u_ff[31]) a_in = 32'(nu64 + tss_pkg::rnd(nu64, 2));
            else          a_in = u_ff;
            state_in = ST_IDX;
         end
         ST_IDX: begin
            sat_in   = |idx[12:8];
            lo_in    = lo_rd;
            mul_a    = signed'(32'(hi_rd - lo_rd));
            mul_b    = signed'({8'd0, a_ff[18:0], 5'd0});
            state_in = ST_TANH;
         end
         ST_TANH: begin
            tfrac = (64'(prod_ff) + 64'd8388608) >> 24;
            if (sat_ff) t_in = signed'(32'(tss_pkg::TANH_ROM[tss_pkg::TANH_DEPTH]));
            else        t_in = signed'(32'(lo_ff) + tfrac[31:0]);
            state_in = neg_ff ? ST_NEGM : ST_WETM;
         end
         ST_NEGM: begin
            mul_a    = t_ff;
            mul_b    = signed'(tss_pkg::K_NEG);
            state_in = ST_NEG;
         end
         ST_NEG: begin
            t_in     = 32'(-tss_pkg::rnd(prod_ff, 16));
            state_in = ST_WETM;
         end
         ST_WETM: begin
            mul_a    = t_ff;
            mul_b    = signed'(32'(mk_status.value));
            state_in = ST_WET;
         end
         ST_WET: begin
            wet_in   = 32'(tss_pkg::rnd(prod_ff, WF));
            mul_a    = w_ff;
            mul_b    = signed'(32'd32768 - 32'(m_cap));
            state_in = ST_MIX1;
         end
         ST_MIX1: begin
            acc_in   = prod_ff;
            mul_a    = wet_ff;
            mul_b    = signed'(32'(m_cap));
            state_in = ST_MIX2;
         end
         ST_MIX2: begin
            acc_in   = acc_ff + prod_ff;
            state_in = ST_MIX3;
         end
         ST_MIX3: begin
            mixed_in = 32'(tss_pkg::rnd(acc_ff, 15));
            state_in = ST_RES;
         end
         ST_RES: begin
            r64 = tss_pkg::rnd(64'(mixed_ff) <<< RSH_L, RSH_R);
            if (r64 > SMAX)      r64 = SMAX;
            else if (r64 < SMIN) r64 = SMIN;
            res_in   = r64[SAMPLE_BITS-1:0];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_ff     <= tss_pkg::RST_DRIVE;
         bias_ff      <= tss_pkg::RST_BIAS;
         sag_ff       <= tss_pkg::RST_SAG;
         mix_cfg_ff   <= tss_pkg::RST_MIX;
         coef_ff      <= tss_pkg::RST_COEF;
         dirty_ff     <= 1'b1;
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         env_ff       <= '0;
      end else begin
         drive_ff     <= drive_in;
         bias_ff      <= bias_in;
         sag_ff       <= sag_in;
         mix_cfg_ff   <= mix_cfg_in;
         coef_ff      <= coef_in;
         dirty_ff     <= dirty_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         env_ff       <= env_in;
      end
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      w_ff        <= w_in;
      x_ff        <= x_in;
      gk_ff       <= gk_in;
      t1_ff       <= t1_in;
      t2_ff       <= t2_in;
      u_ff        <= u_in;
      t_ff        <= t_in;
      wet_ff      <= wet_in;
      mixed_ff    <= mixed_in;
      acc_ff      <= acc_in;
      a_ff        <= a_in;
      neg_ff      <= neg_in;
      sat_ff      <= sat_in;
      lo_ff       <= lo_in;
   end

   tss_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod_ff)
   );

   tss_makeup u_makeup (
      .clock  (clock),
      .reset  (reset),
      .start  (mk_start),
      .drive  (d_cap),
      .status (mk_status)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'(rsp_data_ff);

   // a taken request leaves req_tready low in the cycle after
   `TSS_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)
   // a finished result never overwrites one still waiting
   `TSS_ASSERT_NEXT(a_hold_done, clock, reset,
      state_ff == ST_DONE && rsp_valid_ff && !rsp_tready, state_ff == ST_DONE)
   // no request while the makeup gain is being recomputed
   `TSS_ASSERT_IMP(a_no_req_in_makeup, clock, reset, mk_status.busy, !req_tready)

endmodule

`default_nettype wire

FILE: sv/tss_mul.sv
// Shared signed 32x32 multiplier with registered product.
`default_nettype none

module tss_mul (
   input  wire logic               clock,
   input  wire logic signed [31:0] op_a,
   input  wire logic signed [31:0] op_b,
   output      logic signed [63:0] prod_ff
);

   logic signed [63:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

FILE: sv/tss_makeup.sv
// Makeup gain 1/sqrt(1+8*drive): bit-serial square root then long division.
`default_nettype none

module tss_makeup (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [15:0]            drive,
   output      tss_pkg::mk_status_type status
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_ROOT = 2'd1;
   localparam logic [1:0] PH_DIV  = 2'd2;

   logic [1:0]  phase_ff, phase_in;
   logic [52:0] v_ff, v_in, r_ff, r_in, b_ff, b_in;
   logic [25:0] sq_ff, sq_in, rem_ff, rem_in;
   logic [48:0] num_ff, num_in;
   logic [24:0] q_ff, q_in, mk_ff, mk_in;
   logic [5:0]  cnt_ff, cnt_in;

   logic [52:0] rb;
   logic [52:0] r_nx;
   logic [26:0] cur;

   always_comb begin
      phase_in = phase_ff;
      v_in     = v_ff;
      r_in     = r_ff;
      b_in     = b_ff;
      sq_in    = sq_ff;
      rem_in   = rem_ff;
      num_in   = num_ff;
      q_in     = q_ff;
      mk_in    = mk_ff;
      cnt_in   = cnt_ff;
      rb       = r_ff + b_ff;
      r_nx     = r_ff >> 1;
      cur      = {rem_ff, num_ff[48]};
      case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               v_in     = (53'(drive) * 53'd8 + 53'd32768) << 33;
               r_in     = '0;
               b_in     = 53'd1 << 52;
               phase_in = PH_ROOT;
            end
         end
         PH_ROOT: begin
            if (v_ff >= rb) begin
               v_in = v_ff - rb;
               r_nx = (r_ff >> 1) + b_ff;
            end
            r_in = r_nx;
            b_in = b_ff >> 2;
            if (b_ff == 53'd1) begin
               sq_in    = r_nx[25:0];
               num_in   = (49'd1 << 48) + 49'(r_nx[25:1]);
               rem_in   = '0;
               q_in     = '0;
               cnt_in   = 6'd48;
               phase_in = PH_DIV;
            end
         end
         PH_DIV: begin
            if (cur >= {1'b0, sq_ff}) begin
               rem_in = 26'(cur - {1'b0, sq_ff});
               q_in   = {q_ff[23:0], 1'b1};
            end else begin
               rem_in = cur[25:0];
               q_in   = {q_ff[23:0], 1'b0};
            end
            num_in = {num_ff[47:0], 1'b0};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               mk_in    = q_in;
               phase_in = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
      v_ff   <= v_in;
      r_ff   <= r_in;
      b_ff   <= b_in;
      sq_ff  <= sq_in;
      rem_ff <= rem_in;
      num_ff <= num_in;
      q_ff   <= q_in;
      mk_ff  <= mk_in;
      cnt_ff <= cnt_in;
   end

   assign status.busy  = (phase_ff != PH_IDLE);
   assign status.value = mk_ff;

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the tube saturation stage top level.
`timescale 1ns / 1ps

module testbench;

   localparam int  CLOCK_HALF  = 6;
   localparam int  CYCLE_LIMIT = 1000000;
   localparam int  NUM_PHASES  = 12;
   localparam int  RANDOM_PER_PHASE = 66;
   localparam int  TAIL_CYCLES = 60;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [15:0] sample_in
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [15:0] sample_out
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;

   // shadow of the block's registers and envelope
   logic [15:0] drive_q, bias_q, sag_q, mix_q, coef_q;
   longint unsigned env_q;
   longint tanh_points [0:256];

   logic [15:0] pending_samples [$];
   logic [15:0] expected_samples [$];
   int          mismatches;
   int          cycle_count;
   int          send_gap;
   int          take_stall;
   bit          send_quiet;
   bit          take_quiet;

   tube_saturation_stage_top #(.SAMPLE_BITS(16)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b1;
      #CLOCK_HALF;
      clock = 1'b0;
      #CLOCK_HALF;
   end

   // shift right, rounding half away from zero
   function automatic longint round_shift(input longint v, input int sh);
      longint unsigned m;
      m = (v < 0) ? longint'(-v) : longint'(v);
      m = (m + (64'd1 << (sh - 1))) >> sh;
      return (v < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // tanh over [0,8] in Q.24, built from an exp(-2x) step series in Q2.30
   task automatic fill_tanh_points();
      longint unsigned one, h, term, p, t;
      longint sum;
      one  = 64'd1 << 30;
      h    = (64'd16 << 30) / 256;
      sum  = longint'(one);
      term = one;
      p    = one;
      for (int n = 1; n < 48 && term != 0; n++) begin
         term = ((term * h) >> 30) / longint'(n);
         if (n % 2 == 1) sum = sum - longint'(term);
         else            sum = sum + longint'(term);
      end
      for (int k = 0; k <= 256; k++) begin
         t = ((one - p) << 30) / (one + p);
         tanh_points[k] = longint'((t + 32) >> 6);
         p = (p * longint'(sum) + (one >> 1)) >> 30;
      end
   endtask

   function automatic longint tanh_lookup(input longint a);
      longint unsigned pos, idx, frac, d;
      pos  = (longint'(a) * 256) / 8;
      idx  = pos >> 24;
      frac = pos & ((64'd1 << 24) - 1);
      if (idx >= 256) return tanh_points[256];
      d = tanh_points[idx + 1] - tanh_points[idx];
      return tanh_points[idx] + longint'((d * frac + (64'd1 << 23)) >> 24);
   endfunction

   function automatic longint unsigned clip_unity(input logic [15:0] v);
      return (v > 16'd32768) ? 64'd32768 : 64'(v);
   endfunction

   // expected output for one sample; advances the envelope shadow
   function automatic logic [15:0] saturate_sample(input logic [15:0] raw);
      longint unsigned d, g, m, c, sq, makeup;
      longint s, w, x, ax, bias, term1, term2, u, a, shaped, wet, mixed, res;
      d = clip_unity(drive_q);
      g = clip_unity(sag_q);
      m = clip_unity(mix_q);
      c = 64'(coef_q);
      if (d <= 32 && m <= 32) return raw;   // bypass, envelope holds
      s  = longint'(signed'(raw));
      w  = s * 512;
      x  = round_shift(w * longint'(32768 + 24 * d), 15);
      ax = round_shift((x < 0) ? -x : x, 5);
      env_q = ((longint'(ax) * (65536 - c) + env_q * c + 32768) >> 16) & 64'hFFFFFF;
      bias  = longint'(signed'(bias_q));
      term1 = round_shift(bias * 512 * 26214, 16);
      term2 = round_shift(longint'(env_q * g) * 9830, 26);
      u = x + term1 - term2;
      if (u >= 0) begin
         shaped = tanh_lookup(u);
      end else begin
         a = -u;
         a = a + round_shift(a, 2);
         shaped = -round_shift(tanh_lookup(a) * 55706, 16);
      end
      sq     = int_sqrt((64'd32768 + 8 * d) << 33);
      makeup = ((64'd1 << 48) + sq / 2) / sq;
      wet    = round_shift(shaped * longint'(makeup), 24);
      mixed  = round_shift(w * longint'(32768 - m) + wet * longint'(m), 15);
      res    = round_shift(mixed, 9);
      if (res > 32767)  res = 32767;
      if (res < -32768) res = -32768;
      return res[15:0];
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      mismatches++;
      $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
   endtask

   function automatic int draw_gap(input bit quiet);
      return quiet ? 0 : $urandom_range(0, 14);
   endfunction

   // Request side: one sample at a time from the pending queue, random gaps
   always @(posedge clock) begin
      bit accepted;
      bit next_valid;
      accepted = req_tvalid && req_tready;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         send_gap   = 0;
         send_quiet = 1'b0;
      end else begin
         if (accepted) begin
            expected_samples.push_back(saturate_sample(req_tdata));
            void'(pending_samples.pop_front());
            if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
            send_gap = draw_gap(send_quiet);
         end
         next_valid = 1'b0;
         if (req_tvalid && !accepted) begin
            next_valid = 1'b1;           // hold the request until taken
         end else if (send_gap > 0) begin
            send_gap--;
         end else if (pending_samples.size() > 0) begin
            next_valid = 1'b1;
            req_tdata <= pending_samples[0];
         end
         req_tvalid <= next_valid;
      end
   end

   // Response side: random back-pressure, compare against oldest expectation
   always @(posedge clock) begin
      logic [15:0] want;
      if (reset) begin
         rsp_tready <= 1'b0;
         take_stall = 0;
         take_quiet = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_samples.size() == 0) begin
               report_mismatch("unexpected sample_out", rsp_tdata[15:0], 16'h0);
            end else begin
               want = expected_samples.pop_front();
               if (rsp_tdata[15:0] !== want)
                  report_mismatch("sample_out", rsp_tdata[15:0], want);
            end
            if ($urandom_range(0, 39) == 0) take_quiet = !take_quiet;
            take_stall = draw_gap(take_quiet);
         end
         if (take_stall > 0) begin
            take_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Write one register; csr_valid stays high so the caller can chain writes
   task automatic write_register(input logic [2:0] index, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         tss_pkg::CFG_DRIVE: drive_q = value;
         tss_pkg::CFG_BIAS:  bias_q  = value;
         tss_pkg::CFG_SAG:   sag_q   = value;
         tss_pkg::CFG_MIX:   mix_q   = value;
         tss_pkg::CFG_COEF:  coef_q  = value;
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      @(posedge clock);
      while (pending_samples.size() != 0 || expected_samples.size() != 0 || req_tvalid)
         @(posedge clock);
   endtask

   function automatic logic [15:0] random_sample();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 4)      return 16'($urandom);
      else if (pick < 7) return 16'($urandom_range(0, 4095) - 2048);
      else if (pick < 9) return 16'($urandom_range(0, 511) - 256);
      else               return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
   endfunction

   logic [15:0] phase_regs [NUM_PHASES][5];

   initial begin
      reset       = 1'b1;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      drive_q = tss_pkg::RST_DRIVE;
      bias_q  = tss_pkg::RST_BIAS;
      sag_q   = tss_pkg::RST_SAG;
      mix_q   = tss_pkg::RST_MIX;
      coef_q  = tss_pkg::RST_COEF;
      fill_tanh_points();

      // register order: drive, bias, sag, mix, coefficient
      phase_regs[0]  = '{tss_pkg::RST_DRIVE, tss_pkg::RST_BIAS, tss_pkg::RST_SAG,
                         tss_pkg::RST_MIX, tss_pkg::RST_COEF};
      phase_regs[1]  = '{16'd32768, 16'h7FFF, 16'd32768, 16'd32768, 16'd0};     // instant env
      phase_regs[2]  = '{16'd0, 16'h0000, 16'd0, 16'd0, 16'd65535};             // bypass
      phase_regs[3]  = '{16'd32, 16'h8000, 16'd32768, 16'd32, 16'd1};           // bypass edge
      phase_regs[4]  = '{16'd33, 16'h8000, 16'd0, 16'd32768, 16'd65490};
      phase_regs[5]  = '{16'hFFFF, 16'd12345, 16'hFFFF, 16'hFFFF, 16'd30000};   // over range
      phase_regs[6]  = '{16'd0, 16'h0000, 16'd0, 16'd32768, 16'd65490};
      phase_regs[7]  = '{16'd32768, 16'h8000, 16'd32768, 16'd16384, 16'd0};
      for (int p = 8; p < NUM_PHASES; p++)
         for (int r = 0; r < 5; r++) phase_regs[p][r] = 16'($urandom);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p > 0) begin
            wait_idle();
            write_register(tss_pkg::CFG_DRIVE, phase_regs[p][0]);
            write_register(tss_pkg::CFG_BIAS,  phase_regs[p][1]);
            write_register(tss_pkg::CFG_SAG,   phase_regs[p][2]);
            write_register(tss_pkg::CFG_MIX,   phase_regs[p][3]);
            write_register(tss_pkg::CFG_COEF,  phase_regs[p][4]);
            csr_valid <= 1'b0;
         end
         // directed extremes, then a loud burst to pump the envelope
         pending_samples.push_back(16'h7FFF);
         pending_samples.push_back(16'h8000);
         pending_samples.push_back(16'h0000);
         pending_samples.push_back(16'h0001);
         pending_samples.push_back(16'hFFFF);
         pending_samples.push_back(16'h5555);
         pending_samples.push_back(16'hAAAA);
         for (int i = 0; i < 6; i++)
            pending_samples.push_back(i[0] ? 16'h8000 : 16'h7FFF);
         for (int i = 0; i < RANDOM_PER_PHASE; i++)
            pending_samples.push_back(random_sample());
      end

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_samples.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
